/* sv/brr_pkg.sv */
package brr_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned POS_W        = 4;
    localparam int unsigned HIST_W       = 15;
    localparam int unsigned PCM_W        = 16;
    localparam int unsigned CALC_W       = 21;

    localparam logic [POS_W-1:0] POS_HEADER  = 4'd0;
    localparam logic [POS_W-1:0] POS_LAST    = 4'd8;
    localparam logic [3:0]       RANGE_LIMIT = 4'd13;

    localparam logic signed [CALC_W-1:0] SAT_MAX    = 21'sd32767;
    localparam logic signed [CALC_W-1:0] SAT_MIN    = -21'sd32768;
    localparam logic signed [CALC_W-1:0] NIB_FLOOR  = -21'sd2048;

    typedef enum logic [1:0] {
        FILTER_NONE = 2'd0,
        FILTER_ONE  = 2'd1,
        FILTER_TWO  = 2'd2,
        FILTER_THREE = 2'd3
    } filter_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [3:0]        hdr_range;
        filter_t           filter;
        logic              end_flag;
        logic              clear_hist;
    } brr_entry_t;

endpackage

/* sv/brr_front.sv */
module brr_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                s_tuser,
    output logic                push_valid,
    output brr_pkg::brr_entry_t push_entry,
    input  logic                queue_full
);
    import brr_pkg::*;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] header_reg, header_next;
    logic              stopped_reg, stopped_next;
    logic              pending_reg, pending_next;

    logic [POS_W-1:0]  pos_eff;
    logic              stop_eff;
    logic              pend_eff;
    logic              accept;
    logic              is_header;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        pos_eff      = s_tuser ? POS_HEADER : pos_reg;
        stop_eff     = s_tuser ? 1'b0 : stopped_reg;
        pend_eff     = s_tuser | pending_reg;
        is_header    = (pos_eff == POS_HEADER) || (pos_eff > POS_LAST);

        pos_next     = pos_reg;
        header_next  = header_reg;
        stopped_next = stopped_reg;
        pending_next = pending_reg;
        push_valid   = 1'b0;

        push_entry.data_byte  = s_tdata;
        push_entry.hdr_range  = header_reg[7:4];
        push_entry.filter     = filter_t'(header_reg[3:2]);
        push_entry.end_flag   = (pos_eff == POS_LAST) && header_reg[0];
        push_entry.clear_hist = pend_eff;

        if (accept) begin
            pos_next     = pos_eff;
            stopped_next = stop_eff;
            pending_next = pend_eff;
            if (!stop_eff) begin
                if (is_header) begin
                    header_next = s_tdata;
                    pos_next    = 4'd1;
                end else begin
                    push_valid   = 1'b1;
                    pending_next = 1'b0;
                    if (pos_eff == POS_LAST) begin
                        pos_next     = POS_HEADER;
                        stopped_next = header_reg[0];
                    end else begin
                        pos_next = pos_eff + 4'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= POS_HEADER;
            header_reg  <= '0;
            stopped_reg <= 1'b0;
            pending_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            header_reg  <= header_next;
            stopped_reg <= stopped_next;
            pending_reg <= pending_next;
        end
    end

endmodule

/* sv/brr_queue.sv */
module brr_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    input  brr_pkg::brr_entry_t push_entry,
    output logic                queue_full,
    output logic                pop_valid,
    output brr_pkg::brr_entry_t pop_entry,
    input  logic                pop_ready
);
    import brr_pkg::*;

    brr_entry_t  mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push;
    logic        do_pop;

    assign queue_full = (count_reg == 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && !queue_full;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* sv/brr_back.sv */
module brr_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                pop_valid,
    input  brr_pkg::brr_entry_t pop_entry,
    output logic                pop_ready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,
    output logic                m_tlast,
    output logic                m_tuser
);
    import brr_pkg::*;

    logic                      phase_reg, phase_next;
    logic signed [HIST_W-1:0]  hist1_reg, hist1_next;
    logic signed [HIST_W-1:0]  hist2_reg, hist2_next;
    logic                      valid_reg, valid_next;
    logic [PCM_W-1:0]          data_reg, data_next;
    logic                      last_reg, last_next;
    logic                      end_reg, end_next;

    logic                      out_free;
    logic                      fire;
    logic [3:0]                nib;
    logic signed [CALC_W-1:0]  nib_ext;
    logic signed [CALC_W-1:0]  scaled;
    logic signed [CALC_W-1:0]  h1x;
    logic signed [CALC_W-1:0]  h2x;
    logic signed [CALC_W-1:0]  pred;
    logic signed [CALC_W-1:0]  sum;
    logic signed [CALC_W-1:0]  clamped;
    logic signed [HIST_W-1:0]  h1_eff;
    logic signed [HIST_W-1:0]  h2_eff;
    logic [HIST_W-1:0]         wrapped;

    assign out_free  = !valid_reg || m_tready;
    assign fire      = pop_valid && out_free;
    assign pop_ready = out_free && phase_reg;

    always_comb begin
        nib     = phase_reg ? pop_entry.data_byte[3:0] : pop_entry.data_byte[7:4];
        nib_ext = {{(CALC_W-4){nib[3]}}, nib};
        if (pop_entry.hdr_range < RANGE_LIMIT) begin
            scaled = (nib_ext <<< pop_entry.hdr_range) >>> 1;
        end else begin
            scaled = nib[3] ? NIB_FLOOR : '0;
        end

        h1_eff = (pop_entry.clear_hist && !phase_reg) ? '0 : hist1_reg;
        h2_eff = (pop_entry.clear_hist && !phase_reg) ? '0 : hist2_reg;
        h1x    = {{(CALC_W-HIST_W){h1_eff[HIST_W-1]}}, h1_eff};
        h2x    = {{(CALC_W-HIST_W){h2_eff[HIST_W-1]}}, h2_eff};

        unique case (pop_entry.filter)
            FILTER_ONE: begin
                pred = h1x + ((-h1x) >>> 4);
            end
            FILTER_TWO: begin
                pred = (h1x <<< 1) + ((-((h1x <<< 1) + h1x)) >>> 5)
                     - h2x + (h2x >>> 4);
            end
            FILTER_THREE: begin
                pred = (h1x <<< 1) + ((-((h1x <<< 3) + (h1x <<< 2) + h1x)) >>> 6)
                     - h2x + (((h2x <<< 1) + h2x) >>> 4);
            end
            default: begin
                pred = '0;
            end
        endcase

        sum = scaled + pred;
        if (sum > SAT_MAX) begin
            clamped = SAT_MAX;
        end else if (sum < SAT_MIN) begin
            clamped = SAT_MIN;
        end else begin
            clamped = sum;
        end
        wrapped = clamped[HIST_W-1:0];

        phase_next = phase_reg;
        hist1_next = hist1_reg;
        hist2_next = hist2_reg;
        valid_next = valid_reg && !m_tready;
        data_next  = data_reg;
        last_next  = last_reg;
        end_next   = end_reg;

        if (fire) begin
            phase_next = !phase_reg;
            hist2_next = h1_eff;
            hist1_next = $signed(wrapped);
            valid_next = 1'b1;
            data_next  = {wrapped, 1'b0};
            last_next  = phase_reg;
            end_next   = phase_reg && pop_entry.end_flag;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        last_reg <= last_next;
        end_reg  <= end_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
            hist1_reg <= '0;
            hist2_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            hist1_reg <= hist1_next;
            hist2_reg <= hist2_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = end_reg;

endmodule

/* sv/brr_sample_decoder_top.sv */
// Flow: a payload byte is written into the two-entry queue, then the back end registers its
// two samples on m_tdata in turn; header bytes and ignored bytes give no transaction.
// Throughput: the single sample datapath in the back end produces one sample per cycle while
// m_tready allows; the front end takes new bytes into the queue while it has room.
// Reset: aresetn is synchronous, active low; it clears position, header, history,
// the stop flag and the queue at once, with no clearing pass.
module brr_sample_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] new_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] pcm_sample
    output logic        m_tlast,
    output logic        m_tuser    // [0] end_of_sample
);
    import brr_pkg::*;

    logic       push_valid;
    brr_entry_t push_entry;
    logic       queue_full;
    logic       pop_valid;
    brr_entry_t pop_entry;
    logic       pop_ready;

    brr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .queue_full (queue_full)
    );

    brr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .queue_full (queue_full),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop_ready  (pop_ready)
    );

    brr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_entry (pop_entry),
        .pop_ready (pop_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
